>>> sv/tcbs_pkg.sv
// Package for the turbo code block segmentation block.
// Holds the shared constants, the controller/datapath types and the interleaver size table.
// No dependencies.
package tcbs_pkg;

   localparam int TB_W               = 17;
   localparam int OUT_C_W            = 6;
   localparam int K_W                = 13;
   localparam int IDX_W              = 8;
   localparam int SIZE_TABLE_ENTRIES = 189;
   localparam int CRC_BITS           = 24;
   localparam int MAX_BLOCK          = 6144;
   localparam int SEG_BLOCK          = MAX_BLOCK - CRC_BITS;
   localparam int MIN_BLOCK          = 40;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CBLK,
      ST_SRCH,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic blk_step;
      logic srch_init;
      logic srch_step;
      logic div_init;
      logic div_step;
   } cmd_type;

   typedef struct packed {
      logic blk_done;
      logic srch_done;
      logic div_done;
   } sts_type;

   // Interleaver size at table index idx. Entry 0 is zero; indexes past the
   // table give the largest size.
   function automatic logic [K_W-1:0] size_of(input logic [IDX_W-1:0] idx);
      logic [K_W-1:0] k;
      if (idx == '0) begin
         k = '0;
      end else if (idx <= IDX_W'(60)) begin
         k = K_W'(MIN_BLOCK + 8 * (int'(idx) - 1));
      end else if (idx <= IDX_W'(92)) begin
         k = K_W'(528 + 16 * (int'(idx) - 61));
      end else if (idx <= IDX_W'(124)) begin
         k = K_W'(1056 + 32 * (int'(idx) - 93));
      end else if (idx <= IDX_W'(SIZE_TABLE_ENTRIES - 1)) begin
         k = K_W'(2112 + 64 * (int'(idx) - 125));
      end else begin
         k = K_W'(MAX_BLOCK);
      end
      return k;
   endfunction

endpackage

>>> sv/tcbs_ctrl.sv
// Controller state machine for the turbo code block segmentation block.
// Sequences the block count, size search and small-block count in the datapath.
// Depends on tcbs_pkg.
module tcbs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output tcbs_pkg::cmd_type cmd,
   input  tcbs_pkg::sts_type sts
);
   import tcbs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CBLK;
         end
         ST_CBLK: begin
            if (sts.blk_done) state_in = ST_SRCH;
         end
         ST_SRCH: begin
            if (sts.srch_done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CBLK: begin
            cmd.blk_step  = !sts.blk_done;
            cmd.srch_init = sts.blk_done;
         end
         ST_SRCH: begin
            cmd.srch_step = !sts.srch_done;
            cmd.div_init  = sts.srch_done;
         end
         ST_DIV: begin
            cmd.div_step = !sts.div_done;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The result strobe lasts one cycle and only follows the division phase.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_strobe_after_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_DIV)
      else $error("result strobe without a finished division");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted request did not make the block busy");

endmodule

>>> sv/tcbs_dp.sv
// Datapath for the turbo code block segmentation block.
// Block counter, interleaver size search with one multiplier, and a subtractive divider.
// Depends on tcbs_pkg.
module tcbs_dp #(
   parameter int MAX_TB_BITS = 131071
) (
   input  logic                             clock,
   input  logic [tcbs_pkg::TB_W-1:0]        req_tb_bits,
   input  tcbs_pkg::cmd_type                cmd,
   output tcbs_pkg::sts_type                sts,
   output logic [tcbs_pkg::OUT_C_W-1:0]     rsp_num_blocks,
   output logic [tcbs_pkg::OUT_C_W-1:0]     rsp_num_large,
   output logic [tcbs_pkg::OUT_C_W-1:0]     rsp_num_small,
   output logic [tcbs_pkg::K_W-1:0]         rsp_size_large,
   output logic [tcbs_pkg::K_W-1:0]         rsp_size_small
);
   import tcbs_pkg::*;

   localparam int CMAX = (MAX_TB_BITS + CRC_BITS + SEG_BLOCK - 1) / SEG_BLOCK;
   localparam int CW   = $clog2(CMAX + 1);
   localparam int BW   = $clog2(MAX_TB_BITS + CRC_BITS + 1);
   localparam int XW   = (TB_W > BW) ? TB_W : BW;
   localparam int PW   = CW + K_W;

   logic [BW-1:0]    b_ff, b_in;
   logic [BW-1:0]    rem_ff, rem_in;
   logic             single_ff, single_in;
   logic [CW-1:0]    c_ff, c_in;
   logic [PW-1:0]    bp_ff, bp_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [K_W-1:0]   kp_ff, kp_in;
   logic [K_W-1:0]   km_ff, km_in;
   logic [PW-1:0]    num_ff, num_in;
   logic [K_W-1:0]   den_ff, den_in;
   logic [CW-1:0]    cm_ff, cm_in;

   logic [XW-1:0]    a_x;
   logic [XW-1:0]    a_clamp;
   logic [BW-1:0]    b_new;
   logic [K_W-1:0]   k_cur;
   logic [K_W-1:0]   k_prev;
   logic [PW-1:0]    prod;
   logic [PW-1:0]    bp_new;
   logic             fits;

   assign a_x     = XW'(req_tb_bits);
   assign a_clamp = (a_x > XW'(MAX_TB_BITS)) ? XW'(MAX_TB_BITS) : a_x;
   assign b_new   = BW'(a_clamp) + BW'(CRC_BITS);

   assign k_cur  = size_of(idx_ff);
   assign k_prev = size_of(idx_ff - IDX_W'(1));
   assign prod   = PW'(c_ff) * PW'(k_cur);
   assign fits   = prod >= bp_ff;
   assign bp_new = single_ff ? PW'(b_ff) : PW'(b_ff) + PW'(c_ff) * PW'(CRC_BITS);

   assign sts.blk_done  = single_ff || (rem_ff <= BW'(SEG_BLOCK));
   assign sts.srch_done = fits || (idx_ff == IDX_W'(SIZE_TABLE_ENTRIES - 1));
   assign sts.div_done  = single_ff || (num_ff < PW'(den_ff)) || (cm_ff == c_ff);

   always_comb begin
      b_in      = b_ff;
      rem_in    = rem_ff;
      single_in = single_ff;
      c_in      = c_ff;
      bp_in     = bp_ff;
      idx_in    = idx_ff;
      kp_in     = kp_ff;
      km_in     = km_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      cm_in     = cm_ff;
      if (cmd.load) begin
         b_in      = b_new;
         rem_in    = b_new;
         single_in = b_new <= BW'(MAX_BLOCK);
         c_in      = CW'(1);
      end
      if (cmd.blk_step) begin
         rem_in = rem_ff - BW'(SEG_BLOCK);
         c_in   = c_ff + CW'(1);
      end
      if (cmd.srch_init) begin
         bp_in  = bp_new;
         idx_in = IDX_W'(1);
      end
      if (cmd.srch_step) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.div_init) begin
         // The remainder C*K+ - B' is divided by K+ - K- through repeated subtraction.
         kp_in  = k_cur;
         km_in  = single_ff ? '0 : k_prev;
         num_in = (!single_ff && fits) ? prod - bp_ff : '0;
         den_in = k_cur - k_prev;
         cm_in  = '0;
      end
      if (cmd.div_step) begin
         num_in = num_ff - PW'(den_ff);
         cm_in  = cm_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      b_ff      <= b_in;
      rem_ff    <= rem_in;
      single_ff <= single_in;
      c_ff      <= c_in;
      bp_ff     <= bp_in;
      idx_ff    <= idx_in;
      kp_ff     <= kp_in;
      km_ff     <= km_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      cm_ff     <= cm_in;
   end

   assign rsp_num_blocks = OUT_C_W'(c_ff);
   assign rsp_num_large  = OUT_C_W'(c_ff - cm_ff);
   assign rsp_num_small  = OUT_C_W'(cm_ff);
   assign rsp_size_large = kp_ff;
   assign rsp_size_small = km_ff;

endmodule

>>> sv/turbo_code_block_segmentation.sv
// Top level of the turbo code block segmentation block.
// Joins the controller (tcbs_ctrl) and the datapath (tcbs_dp); uses tcbs_pkg.
//
// One request carries a transport block size; one result comes back with the
// number of code blocks and the two block sizes with their counts. A request
// is taken when start is high and busy is low, and busy then stays high until
// the result has been shown. The result is on the rsp_ ports for exactly one
// cycle, marked by rsp_valid, and cannot be held off by the receiver. The strobe
// follows the block count C, the search for K+ in the interleaver size table and
// the count C- of small blocks by repeated subtraction, in that order; the walk
// over the size table with one multiplier is the longest of these steps. busy
// drops the cycle after the strobe.
module turbo_code_block_segmentation #(
   parameter int MAX_TB_BITS = 131071
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [tcbs_pkg::TB_W-1:0]    req_tb_bits,
   output logic                         rsp_valid,
   output logic [tcbs_pkg::OUT_C_W-1:0] rsp_num_blocks,
   output logic [tcbs_pkg::OUT_C_W-1:0] rsp_num_large,
   output logic [tcbs_pkg::OUT_C_W-1:0] rsp_num_small,
   output logic [tcbs_pkg::K_W-1:0]     rsp_size_large,
   output logic [tcbs_pkg::K_W-1:0]     rsp_size_small
);
   import tcbs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tcbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   tcbs_dp #(
      .MAX_TB_BITS (MAX_TB_BITS)
   ) u_dp (
      .clock          (clock),
      .req_tb_bits    (req_tb_bits),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_num_blocks (rsp_num_blocks),
      .rsp_num_large  (rsp_num_large),
      .rsp_num_small  (rsp_num_small),
      .rsp_size_large (rsp_size_large),
      .rsp_size_small (rsp_size_small)
   );

   a_counts_add_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> OUT_C_W'(rsp_num_large + rsp_num_small) == rsp_num_blocks)
      else $error("large and small block counts do not add up");

   a_size_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_size_large >= K_W'(MIN_BLOCK))
                 && (rsp_size_large <= K_W'(MAX_BLOCK))
                 && (rsp_size_small < rsp_size_large))
      else $error("block sizes out of order or out of range");

   a_single_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_num_blocks == OUT_C_W'(1))
         |-> (rsp_size_small == '0) && (rsp_num_small == '0))
      else $error("single block result carries a small block");

endmodule

>>> test/tcbs_checker.sv
// Checker for the turbo code block segmentation block: watches the request and
// result ports, predicts each segmentation and compares it with the strobed result.
// Depends on tcbs_pkg for widths and constants.
module tcbs_checker #(
   parameter int MAX_TB_BITS = 131071
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [tcbs_pkg::TB_W-1:0]    req_tb_bits,
   input  logic                         rsp_valid,
   input  logic [tcbs_pkg::OUT_C_W-1:0] rsp_num_blocks,
   input  logic [tcbs_pkg::OUT_C_W-1:0] rsp_num_large,
   input  logic [tcbs_pkg::OUT_C_W-1:0] rsp_num_small,
   input  logic [tcbs_pkg::K_W-1:0]     rsp_size_large,
   input  logic [tcbs_pkg::K_W-1:0]     rsp_size_small,
   output int                           fail_count,
   output int                           pending,
   output int                           results_checked,
   output int                           multi_block_results
);

   typedef struct packed {
      logic [tcbs_pkg::OUT_C_W-1:0] num_blocks;
      logic [tcbs_pkg::OUT_C_W-1:0] num_large;
      logic [tcbs_pkg::OUT_C_W-1:0] num_small;
      logic [tcbs_pkg::K_W-1:0]     size_large;
      logic [tcbs_pkg::K_W-1:0]     size_small;
   } segmentation_t;

   int            interleaver_sizes [tcbs_pkg::SIZE_TABLE_ENTRIES];
   segmentation_t segmentation_q [$];
   int            mismatches = 0;
   int            checked    = 0;
   int            multi      = 0;

   initial begin
      fail_count          = 0;
      pending             = 0;
      results_checked     = 0;
      multi_block_results = 0;
   end

   // Entry 0 is zero; the step between sizes doubles at 512, 1024 and 2048.
   initial begin
      int k;
      k = tcbs_pkg::MIN_BLOCK;
      interleaver_sizes[0] = 0;
      for (int i = 1; i < tcbs_pkg::SIZE_TABLE_ENTRIES; i++) begin
         interleaver_sizes[i] = k;
         if (k < 512) k += 8;
         else if (k < 1024) k += 16;
         else if (k < 2048) k += 32;
         else k += 64;
      end
   end

   function automatic segmentation_t compute_segmentation(input logic [tcbs_pkg::TB_W-1:0] tb);
      segmentation_t seg;
      int a, b, bp, c, kp, km, cm, cp;
      bit found;
      a = int'(tb);
      if (a > MAX_TB_BITS) a = MAX_TB_BITS;
      b = a + tcbs_pkg::CRC_BITS;
      if (b <= tcbs_pkg::MAX_BLOCK) begin
         c  = 1;
         bp = b;
      end else begin
         c  = (b + tcbs_pkg::SEG_BLOCK - 1) / tcbs_pkg::SEG_BLOCK;
         bp = b + c * tcbs_pkg::CRC_BITS;
      end
      // Smallest table size that holds the padded block; the last size if none does.
      kp    = interleaver_sizes[tcbs_pkg::SIZE_TABLE_ENTRIES - 1];
      found = 0;
      for (int i = 0; i < tcbs_pkg::SIZE_TABLE_ENTRIES; i++) begin
         if (!found && c * interleaver_sizes[i] >= bp) begin
            kp    = interleaver_sizes[i];
            found = 1;
         end
      end
      if (c == 1) begin
         cp = 1;
         km = 0;
         cm = 0;
      end else begin
         km    = 0;
         found = 0;
         for (int i = tcbs_pkg::SIZE_TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!found && interleaver_sizes[i] < kp) begin
               km    = interleaver_sizes[i];
               found = 1;
            end
         end
         if (c * kp >= bp && kp > km) cm = (c * kp - bp) / (kp - km);
         else cm = 0;
         if (cm > c) cm = c;
         cp = c - cm;
      end
      seg.num_blocks = c[tcbs_pkg::OUT_C_W-1:0];
      seg.num_large  = cp[tcbs_pkg::OUT_C_W-1:0];
      seg.num_small  = cm[tcbs_pkg::OUT_C_W-1:0];
      seg.size_large = kp[tcbs_pkg::K_W-1:0];
      seg.size_small = km[tcbs_pkg::K_W-1:0];
      return seg;
   endfunction

   always @(posedge clock) begin
      segmentation_t got, want;
      if (reset) begin
         segmentation_q.delete();
      end else begin
         // Results are compared before the new request is queued, so a stray
         // strobe is never matched against a request taken at the same edge.
         if (rsp_valid === 1'b1) begin
            got.num_blocks = rsp_num_blocks;
            got.num_large  = rsp_num_large;
            got.num_small  = rsp_num_small;
            got.size_large = rsp_size_large;
            got.size_small = rsp_size_small;
            checked++;
            if (segmentation_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("checker: result with no request waiting: C=%0d C+=%0d C-=%0d K+=%0d K-=%0d",
                           got.num_blocks, got.num_large, got.num_small,
                           got.size_large, got.size_small);
            end else begin
               want = segmentation_q.pop_front();
               if (want.num_blocks > 1) multi++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"checker: mismatch: expected C=%0d C+=%0d C-=%0d K+=%0d K-=%0d,",
                               " got C=%0d C+=%0d C-=%0d K+=%0d K-=%0d"},
                              want.num_blocks, want.num_large, want.num_small,
                              want.size_large, want.size_small,
                              got.num_blocks, got.num_large, got.num_small,
                              got.size_large, got.size_small);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            segmentation_q.push_back(compute_segmentation(req_tb_bits));
      end
      fail_count          <= mismatches;
      pending             <= segmentation_q.size();
      results_checked     <= checked;
      multi_block_results <= multi;
   end

endmodule

>>> test/testbench.sv
// Top of the turbo code block segmentation testbench: clock, reset, request
// stimulus and the verdict. Instantiates turbo_code_block_segmentation and
// tcbs_checker; uses tcbs_pkg.
module testbench;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int DRAIN_CYCLES = 300;
   localparam int PHASE_ITEMS  = 335;

   typedef logic [tcbs_pkg::TB_W-1:0] tb_bits_t;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic [tcbs_pkg::TB_W-1:0]    req_tb_bits = '0;
   logic                         busy;
   logic                         rsp_valid;
   logic [tcbs_pkg::OUT_C_W-1:0] rsp_num_blocks;
   logic [tcbs_pkg::OUT_C_W-1:0] rsp_num_large;
   logic [tcbs_pkg::OUT_C_W-1:0] rsp_num_small;
   logic [tcbs_pkg::K_W-1:0]     rsp_size_large;
   logic [tcbs_pkg::K_W-1:0]     rsp_size_small;

   int fail_count;
   int pending;
   int results_checked;
   int multi_block_results;
   int cycle_count = 0;
   int requests_sent = 0;

   always #10 clock = ~clock;

   turbo_code_block_segmentation u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_tb_bits    (req_tb_bits),
      .rsp_valid      (rsp_valid),
      .rsp_num_blocks (rsp_num_blocks),
      .rsp_num_large  (rsp_num_large),
      .rsp_num_small  (rsp_num_small),
      .rsp_size_large (rsp_size_large),
      .rsp_size_small (rsp_size_small)
   );

   tcbs_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_tb_bits         (req_tb_bits),
      .rsp_valid           (rsp_valid),
      .rsp_num_blocks      (rsp_num_blocks),
      .rsp_num_large       (rsp_num_large),
      .rsp_num_small       (rsp_num_small),
      .rsp_size_large      (rsp_size_large),
      .rsp_size_small      (rsp_size_small),
      .fail_count          (fail_count),
      .pending             (pending),
      .results_checked     (results_checked),
      .multi_block_results (multi_block_results)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("testbench: timeout after %0d cycles", cycle_count);
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Holds start high until the request is taken; values read right after the
   // edge are the ones the block saw at that edge.
   task automatic send_request(input logic [tcbs_pkg::TB_W-1:0] tb);
      start       <= 1'b1;
      req_tb_bits <= tb;
      do @(posedge clock); while (busy !== 1'b0);
      requests_sent++;
   endtask

   // Idle cycles before a request; now and then a long gap so that the pause
   // lands at any point of the block's table walk.
   task automatic idle_before_request(input int idle_pct);
      int gap;
      gap = 0;
      if (idle_pct > 0) begin
         while ($urandom_range(99) < idle_pct) gap++;
         if ($urandom_range(7) == 0) gap += $urandom_range(300, 1);
      end
      if (gap > 0) begin
         start       <= 1'b0;
         req_tb_bits <= tb_bits_t'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic tb_bits_t clamp_tb(input int a);
      if (a < 0) a = 0;
      if (a > 131071) a = 131071;
      return tb_bits_t'(a);
   endfunction

   // Mix of full-range sizes, single-block sizes, sizes near a change of the
   // block count and sizes near a step of the interleaver table.
   function automatic tb_bits_t pick_tb_bits();
      int sel, k, idx;
      sel = $urandom_range(99);
      if (sel < 40) begin
         return tb_bits_t'($urandom);
      end else if (sel < 70) begin
         return tb_bits_t'($urandom_range(tcbs_pkg::SEG_BLOCK, 0));
      end else if (sel < 90) begin
         k = $urandom_range(21, 1);
         return clamp_tb(k * tcbs_pkg::SEG_BLOCK - tcbs_pkg::CRC_BITS
                         + $urandom_range(4) - 2);
      end else begin
         idx = $urandom_range(tcbs_pkg::SIZE_TABLE_ENTRIES - 1, 1);
         k   = u_checker.interleaver_sizes[idx];
         return clamp_tb(k - tcbs_pkg::CRC_BITS + $urandom_range(2) - 1);
      end
   endfunction

   task automatic wait_all_results();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int directed [] = '{0, 1, 16, 17, 488, 489, 1000, 1001, 2024, 2025,
                          6119, 6120, 6121, 12216, 12217, 18336, 18337,
                          65535, 65536, 87381, 43690, 131047, 131070, 131071};
      int idle_pattern [4] = '{0, 79, 0, 22};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extremes of the size, the single/multi block edge and the table steps.
      foreach (directed[i]) send_request(tb_bits_t'(directed[i]));

      foreach (idle_pattern[p]) begin
         // The sender holds off until every result of the last phase is in.
         start <= 1'b0;
         wait_all_results();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            idle_before_request(idle_pattern[p]);
            send_request(pick_tb_bits());
         end
      end

      start <= 1'b0;
      wait_all_results();

      $display("testbench: %0d requests sent, %0d results checked, %0d of them multi-block",
               requests_sent, results_checked, multi_block_results);
      $display("testbench: sender idle patterns of 0, 79 and 22 percent, %0d mismatches",
               fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

>>> turbo_code_block_segmentation.f
sv/tcbs_pkg.sv
sv/tcbs_ctrl.sv
sv/tcbs_dp.sv
sv/turbo_code_block_segmentation.sv
test/tcbs_checker.sv
test/testbench.sv
